@@ rtl/mtfdc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtfdc_pkg
// Shared types and constants for the move-to-front distance coder.
// ---------------------------------------------------------------------------
package mtfdc_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int SYM_W           = 32;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture symbol, k = 0, carry = symbol
		logic scan;       // write carry at k
		logic advance;    // k++, carry = read data
		logic to_append;  // k++, carry = read data, then append
		logic append;     // write carry at k, count++
		logic hit;        // result = k, not new
		logic miss;       // result = -symbol, new
		logic emit;       // move result into output register
	} mtfdc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic match;
		logic last;
		logic full;
		logic out_busy;
	} mtfdc_sts_t;

endpackage

@@ rtl/move_to_front_distance_coder_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// move_to_front_distance_coder_unit
// Move-to-front coder over a recency list of distinct 32-bit symbols.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata                  | tuser      | beat
//  --------+-----+------------------------+------------+-------------------
//  s_*     | in  | [31:0] symbol (signed) | -          | one symbol
//  m_*     | out | [31:0] code (signed)   | [0] is_new | one code per symbol
//
//  Flow: one symbol at a time. A hit stops the scan at its list position;
//  a miss scans every listed entry. The cost is the list scan: one memory
//  entry compared and shifted down per cycle, one read and one write port.
//  Reset: empties the list (count to zero); the memory itself is not
//  cleared, entries past the count are never compared.
//  Stalls: a result waits in the output register; the next symbol is taken
//  as soon as the result has moved there, and the coder only holds when a
//  second result is ready while the first is still not taken.
//
// ---------------------------------------------------------------------------
module move_to_front_distance_coder_unit
	import mtfdc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF   // 2 .. 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [31:0] symbol
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] code
	output logic        m_tuser     // [0] is_new
);

	mtfdc_cmd_t cmd;
	mtfdc_sts_t sts;

	// sequencer: walks accept -> load -> (scan) -> (append) -> done
	mtfdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// list memory, scan registers, result and output beat registers
	mtfdc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_symbol  (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_code   (m_tdata),
		.out_is_new (m_tuser)
	);

endmodule

@@ rtl/mtfdc_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtfdc_ctrl
// Sequencer: accept, scan the recency list, append, hand off the result.
// ---------------------------------------------------------------------------
module mtfdc_ctrl
	import mtfdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	input  mtfdc_sts_t sts,
	output mtfdc_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOAD   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_APPEND = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// entry 0 is being read this cycle
				if (sts.empty) begin
					cmd.miss = 1'b1;
					state_d  = ST_APPEND;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match) begin
					cmd.hit = 1'b1;
					state_d = ST_DONE;
				end else if (sts.last) begin
					cmd.miss = 1'b1;
					if (sts.full) begin
						state_d = ST_DONE;   // back entry drops out
					end else begin
						cmd.to_append = 1'b1;
						state_d       = ST_APPEND;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/mtfdc_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtfdc_dp
// Datapath: recency list memory, scan index, carry, result and output regs.
// ---------------------------------------------------------------------------
module mtfdc_dp
	import mtfdc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SYM_W-1:0] in_symbol,
	input  mtfdc_cmd_t       cmd,
	output mtfdc_sts_t       sts,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [SYM_W-1:0] out_code,
	output logic             out_is_new
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [SYM_W-1:0] mem_q [TABLE_DEPTH];
	logic [SYM_W-1:0] rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;

	logic [SYM_W-1:0] sym_q;
	logic [SYM_W-1:0] carry_q;
	logic [IDX_W-1:0] k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] k_next;

	logic [SYM_W-1:0] res_code_q;
	logic             res_new_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_code_q;
	logic             out_new_q;

	assign k_next = CNT_W'(k_q) + CNT_W'(1);

	assign sts.empty    = (cnt_q == '0);
	assign sts.match    = (rd_q == sym_q);
	assign sts.last     = (k_next == cnt_q);
	assign sts.full     = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign sts.out_busy = out_valid_q;

	// the next entry is fetched while the current one is compared; outside the scan
	// entry 0 is read so it is ready for the first compare
	always_comb begin
		if (!cmd.scan || sts.last) begin
			rd_addr = '0;
		end else begin
			rd_addr = IDX_W'(k_next);
		end
	end

	assign wr_en = cmd.scan || cmd.append;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[k_q] <= carry_q;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q   <= in_symbol;
			carry_q <= in_symbol;
			k_q     <= '0;
		end else if (cmd.advance || cmd.to_append) begin
			carry_q <= rd_q;
			k_q     <= IDX_W'(k_next);
		end
		if (cmd.hit) begin
			res_code_q <= SYM_W'(k_q);
			res_new_q  <= 1'b0;
		end else if (cmd.miss) begin
			res_code_q <= '0 - sym_q;
			res_new_q  <= 1'b1;
		end
		if (cmd.emit) begin
			out_code_q <= res_code_q;
			out_new_q  <= res_new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_code   = out_code_q;
	assign out_is_new = out_new_q;

endmodule

@@ rtl/mtfdc_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtfdc_chk
// Port-level checks for the move-to-front distance coder.
// ---------------------------------------------------------------------------
module mtfdc_chk
	import mtfdc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// a held beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn while stalled");

	// one symbol in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous symbol in work");

	// a hit code is a list position
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata >> IDX_W) == 32'd0 &&
			m_tdata < 32'(TABLE_DEPTH))
		else $error("hit position beyond list depth");

	// after an accept (output idle) no result is offered during the load state and the scan or append state after it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
		else $error("result appeared too early");

endmodule

bind move_to_front_distance_coder_unit mtfdc_chk #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_mtfdc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
